>>> design/alr_pkg.sv
// Shared types and constants for the antialiased line rasterizer.
`timescale 1ns / 1ps
package alr_pkg;
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_MIDDLE = 2'd2;

	localparam logic [2:0] CFG_COLOR  = 3'd0;
	localparam logic [2:0] CFG_ENABLE = 3'd1;
	localparam logic [2:0] CFG_LEFT   = 3'd2;
	localparam logic [2:0] CFG_TOP    = 3'd3;
	localparam logic [2:0] CFG_RIGHT  = 3'd4;
	localparam logic [2:0] CFG_BOTTOM = 3'd5;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic finish_load;
		logic emit;
	} alr_cmd_t;

	typedef struct packed {
		logic div_done;
		logic active;
		logic out_busy;
	} alr_status_t;
endpackage

>>> design/antialiased_line_rasterizer_core.sv
// Top level of the antialiased line rasterizer.
`timescale 1ns / 1ps
// A load request runs a bit-serial restoring divider for the gradient and produces no
// pixels; a step request, when drawing is enabled and a line is active, yields two pixels
// on consecutive output beats, and the input stays stalled until both have left.
// Configuration is written through cfg_valid/cfg_ready.
module antialiased_line_rasterizer_core import alr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [12:0]           pixel_x,
	output logic [12:0]           pixel_y,
	output logic [31:0]           pixel_argb,
	output logic                  visible,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	logic [31:0] color_q;
	logic        enable_q;
	logic [11:0] left_q, top_q;
	logic [12:0] right_q, bottom_q;
	alr_cmd_t    cmd;
	alr_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '1; enable_q <= 1'b1; left_q <= '0; top_q <= '0;
			right_q <= 13'd4096; bottom_q <= 13'd4096;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COLOR:  color_q  <= cfg_data;
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_LEFT:   left_q   <= cfg_data[11:0];
				CFG_TOP:    top_q    <= cfg_data[11:0];
				CFG_RIGHT:  right_q  <= cfg_data[12:0];
				CFG_BOTTOM: bottom_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	alr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_req_type(req_type), .draw_enable(enable_q),
		.status, .in_stall, .cmd
	);

	alr_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .status, .start_x, .start_y, .end_x, .end_y,
		.line_color(color_q), .clip_left(left_q), .clip_top(top_q),
		.clip_right(right_q), .clip_bottom(bottom_q), .out_stall, .out_valid,
		.pixel_x, .pixel_y, .pixel_argb, .visible, .last
	);
endmodule

>>> design/alr_ctrl.sv
// Controller state machine for the antialiased line rasterizer.
`timescale 1ns / 1ps
module alr_ctrl import alr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_req_type,
	input  logic        draw_enable,
	input  alr_status_t status,
	output logic        in_stall,
	output alr_cmd_t    cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic       take;

	assign in_stall = (state_q != ST_IDLE) || status.out_busy;
	assign take     = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.load      = take && (in_req_type == REQ_LOAD);
		cmd.emit      = take && (in_req_type == REQ_STEP) && draw_enable && status.active;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.finish_load = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_DIV;
				ST_DIV:  if (status.div_done) state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> design/alr_datapath.sv
// Datapath: setup, restoring divider, crossing accumulator and pixel pair output.
`timescale 1ns / 1ps
module alr_datapath import alr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alr_cmd_t              cmd,
	output alr_status_t           status,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [31:0]           line_color,
	input  logic [11:0]           clip_left,
	input  logic [11:0]           clip_top,
	input  logic [12:0]           clip_right,
	input  logic [12:0]           clip_bottom,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [12:0]           pixel_x,
	output logic [12:0]           pixel_y,
	output logic [31:0]           pixel_argb,
	output logic                  visible,
	output logic                  last
);
	localparam int CW = COORD_BITS + 1;
	localparam int GW = FRAC_BITS + 2;
	localparam int AW = COORD_BITS + FRAC_BITS + 2;
	localparam int NW = COORD_BITS + FRAC_BITS;
	localparam int DCW = $clog2(NW + 1);
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

	logic              active_q, steep_q, neg_q;
	logic [1:0]        phase_q;
	logic [CW-1:0]     column_q, last_column_q, first_row_q, last_row_q;
	logic [GW-1:0]     gradient_q;
	logic [AW-1:0]     crossing_q;
	logic [NW-1:0]     quo_q;
	logic [COORD_BITS:0] rem_q;
	logic [COORD_BITS-1:0] dmaj_q;
	logic [DCW-1:0]    dcnt_q;

	logic [COORD_BITS-1:0] adx, ady, a0, b0, a1, b1, dmin;
	logic                  stp;
	logic [COORD_BITS:0]   rem_sh;

	always_comb begin
		adx = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
		ady = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
		stp = adx < ady;
		a0 = stp ? start_y : start_x;
		b0 = stp ? start_x : start_y;
		a1 = stp ? end_y : end_x;
		b1 = stp ? end_x : end_y;
		if (a1 < a0) begin
			a0 = stp ? end_y : end_x;
			b0 = stp ? end_x : end_y;
			a1 = stp ? start_y : start_x;
			b1 = stp ? start_x : start_y;
		end
		dmin = (b1 < b0) ? b0 - b1 : b1 - b0;
		rem_sh = {rem_q[COORD_BITS-1:0], quo_q[NW-1]};
	end

	assign status.div_done = (dcnt_q == DCW'(NW - 1));
	assign status.active   = active_q;
	assign status.out_busy = out_valid;

	// magnitude and signed gradient after the division
	logic [GW-1:0] mag, grad_n;
	assign mag    = (dmaj_q == '0) ? '0 : GW'(quo_q);
	assign grad_n = neg_q ? GW'(-mag) : mag;

	// pixel pair
	logic             done;
	logic [CW-1:0]    p_col, p_row;
	logic [FRAC_BITS:0] p_cov, n_cov;
	logic             n_last;
	logic [FRAC_BITS-1:0] frac;
	assign frac = crossing_q[FRAC_BITS-1:0];
	assign done = ({1'b0, column_q} + 1'b1) >= {1'b0, last_column_q};

	always_comb begin
		p_col = column_q;
		p_row = first_row_q;
		p_cov = HALF;
		n_cov = '0;
		n_last = 1'b0;
		case (phase_q)
			PH_FIRST: ;
			PH_SECOND: begin
				p_col = last_column_q;
				p_row = last_row_q;
				n_last = done;
			end
			default: begin
				p_row = crossing_q[FRAC_BITS +: CW];
				p_cov = ONE - {1'b0, frac};
				n_cov = {1'b0, frac};
				n_last = done;
			end
		endcase
	end

	// second pixel held while the first is shown
	logic [CW-1:0]      hold_col_q, hold_row_q, pcol_q, prow_q;
	logic [FRAC_BITS:0] hold_cov_q, pcov_q;
	logic               hold_last_q, plast_q, hold_q, pst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0; steep_q <= 1'b0; phase_q <= PH_FIRST;
			column_q <= '0; last_column_q <= '0; first_row_q <= '0; last_row_q <= '0;
			gradient_q <= '0; crossing_q <= '0; dcnt_q <= '0;
			neg_q <= 1'b0; dmaj_q <= '0; quo_q <= '0; rem_q <= '0;
			out_valid <= 1'b0; hold_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				steep_q <= stp;
				neg_q <= b1 < b0;
				column_q <= CW'(a0);
				last_column_q <= CW'(a1);
				first_row_q <= CW'(b0);
				last_row_q <= CW'(b1);
				dmaj_q <= a1 - a0;
				quo_q <= {dmin, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				dcnt_q <= '0;
				phase_q <= PH_FIRST;
				active_q <= 1'b1;
			end
			if (cmd.div_step) begin
				if (rem_sh >= {1'b0, dmaj_q}) begin
					rem_q <= rem_sh - {1'b0, dmaj_q};
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.finish_load) begin
				gradient_q <= grad_n;
				crossing_q <= AW'({first_row_q, {FRAC_BITS{1'b0}}}) + {{(AW-GW){grad_n[GW-1]}}, grad_n};
			end
			if (cmd.emit) begin
				if (phase_q == PH_FIRST) begin
					phase_q <= PH_SECOND;
				end else begin
					column_q <= column_q + 1'b1;
					if (phase_q != PH_SECOND)
						crossing_q <= crossing_q + {{(AW-GW){gradient_q[GW-1]}}, gradient_q};
					if (done) active_q <= 1'b0;
					else if (phase_q == PH_SECOND) phase_q <= PH_MIDDLE;
				end
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
				hold_q <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= hold_q;
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pcol_q <= p_col; prow_q <= p_row; pcov_q <= p_cov; plast_q <= 1'b0;
			hold_col_q <= p_col; hold_row_q <= p_row + 1'b1;
			hold_cov_q <= n_cov; hold_last_q <= n_last;
			pst_q <= steep_q;
		end else if (out_valid && !out_stall && hold_q) begin
			pcol_q <= hold_col_q; prow_q <= hold_row_q;
			pcov_q <= hold_cov_q; plast_q <= hold_last_q;
		end
	end

	logic [FRAC_BITS+8:0] prod;
	logic [12:0] px, py;
	assign prod = pcov_q * line_color[31:24];
	assign px = 13'(pst_q ? prow_q : pcol_q);
	assign py = 13'(pst_q ? pcol_q : prow_q);
	assign pixel_x = px;
	assign pixel_y = py;
	assign pixel_argb = {prod[FRAC_BITS +: 8], line_color[23:0]};
	assign visible = (px >= {1'b0, clip_left}) && (px < clip_right)
		&& (py >= {1'b0, clip_top}) && (py < clip_bottom);
	assign last = plast_q;
endmodule

>>> design/alr_checker.sv
// Port checker for the antialiased line rasterizer, bound to the top level.
`timescale 1ns / 1ps
module alr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] pixel_x,
	input logic [31:0] pixel_argb
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_argb))
		else $error("output request changed while stalled");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while pixel pending");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !out_stall |=> out_valid)
		else $error("pixel pair broken");
endmodule

bind antialiased_line_rasterizer_core alr_checker u_alr_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .pixel_x, .pixel_argb
);

>>> verif/antialiased_line_rasterizer_core_tb.sv
// Self-checking testbench for the antialiased line rasterizer core.
`timescale 1ns / 1ps
module antialiased_line_rasterizer_core_tb;
	import alr_pkg::*;

	localparam logic [2:0] CFG_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = REQ_LOAD;
	logic [11:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [12:0] pixel_x, pixel_y;
	logic [31:0] pixel_argb;
	logic visible, last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = CFG_COLOR;
	logic [31:0] cfg_data = '0;

	typedef struct packed {
		logic [12:0] x;
		logic [12:0] y;
		logic [31:0] argb;
		logic vis;
		logic lst;
	} pixel_t;

	pixel_t pending_pixels[$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// predictor state
	logic [31:0] m_color;
	logic m_enable;
	logic [12:0] m_left, m_top, m_right, m_bottom;
	logic m_active, m_steep;
	logic [1:0] m_phase;
	logic [12:0] m_col, m_last_col, m_first_row, m_last_row;
	logic [17:0] m_grad;
	logic [29:0] m_cross;

	antialiased_line_rasterizer_core u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	always @(posedge clk) begin
		pixel_t e;
		if (out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				report("unexpected pixel", {19'd0, pixel_x}, 0);
			end else begin
				e = pending_pixels.pop_front();
				if (pixel_x !== e.x) report("pixel_x", {19'd0, pixel_x}, {19'd0, e.x});
				if (pixel_y !== e.y) report("pixel_y", {19'd0, pixel_y}, {19'd0, e.y});
				if (pixel_argb !== e.argb) report("pixel_argb", pixel_argb, e.argb);
				if (visible !== e.vis) report("visible", {31'd0, visible}, {31'd0, e.vis});
				if (last !== e.lst) report("last", {31'd0, last}, {31'd0, e.lst});
			end
		end
	end

	function automatic void model_reset();
		m_color = 32'hFFFF_FFFF; m_enable = 1'b1;
		m_left = 0; m_top = 0; m_right = 13'd4096; m_bottom = 13'd4096;
		m_active = 0; m_steep = 0; m_phase = PH_FIRST;
		m_col = 0; m_last_col = 0; m_first_row = 0; m_last_row = 0;
		m_grad = 0; m_cross = 0;
	endfunction

	function automatic void push_pixel(input logic [12:0] col, input logic [12:0] row,
			input logic [16:0] cov, input logic lst);
		pixel_t p;
		logic [24:0] prod;
		prod = cov * m_color[31:24];
		p.x = m_steep ? row : col;
		p.y = m_steep ? col : row;
		p.argb = {prod[23:16], m_color[23:0]};
		p.vis = (p.x >= m_left) && (p.x < m_right) && (p.y >= m_top) && (p.y < m_bottom);
		p.lst = lst;
		pending_pixels.push_back(p);
	endfunction

	function automatic void predict_pixels(input logic rt, input logic [11:0] x1,
			input logic [11:0] y1, input logic [11:0] x2, input logic [11:0] y2);
		logic [11:0] a0, b0, a1, b1, t, adx, ady, dmaj, dmin;
		logic [29:0] mag;
		logic neg, done;
		logic [12:0] row;
		logic [15:0] f;
		if (rt == REQ_LOAD) begin
			adx = x2 >= x1 ? x2 - x1 : x1 - x2;
			ady = y2 >= y1 ? y2 - y1 : y1 - y2;
			m_steep = adx < ady;
			if (m_steep) begin a0 = y1; b0 = x1; a1 = y2; b1 = x2; end
			else begin a0 = x1; b0 = y1; a1 = x2; b1 = y2; end
			if (a1 < a0) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			dmaj = a1 - a0;
			neg = b1 < b0;
			dmin = neg ? b0 - b1 : b1 - b0;
			mag = (dmaj == 0) ? 30'd0 : ({18'd0, dmin} << 16) / dmaj;
			m_grad = neg ? 18'(-mag) : mag[17:0];
			m_col = {1'b0, a0}; m_last_col = {1'b0, a1};
			m_first_row = {1'b0, b0}; m_last_row = {1'b0, b1};
			m_cross = ({18'd0, b0} << 16) + {{12{m_grad[17]}}, m_grad};
			m_phase = PH_FIRST;
			m_active = 1;
			return;
		end
		if (!m_enable || !m_active) return;
		if (m_phase == PH_FIRST) begin
			push_pixel(m_col, m_first_row, 17'h08000, 1'b0);
			push_pixel(m_col, m_first_row + 13'd1, 17'd0, 1'b0);
			m_phase = PH_SECOND;
		end else if (m_phase == PH_SECOND) begin
			done = {1'b0, m_col} + 14'd1 >= {1'b0, m_last_col};
			push_pixel(m_last_col, m_last_row, 17'h08000, 1'b0);
			push_pixel(m_last_col, m_last_row + 13'd1, 17'd0, done);
			m_col = m_col + 13'd1;
			if (done) m_active = 0;
			else m_phase = PH_MIDDLE;
		end else if (m_phase == PH_MIDDLE) begin
			row = m_cross[28:16];
			f = m_cross[15:0];
			done = {1'b0, m_col} + 14'd1 >= {1'b0, m_last_col};
			push_pixel(m_col, row, 17'h10000 - {1'b0, f}, 1'b0);
			push_pixel(m_col, row + 13'd1, {1'b0, f}, done);
			m_col = m_col + 13'd1;
			m_cross = m_cross + {{12{m_grad[17]}}, m_grad};
			if (done) m_active = 0;
		end else begin
			m_active = 0;
		end
	endfunction

	task automatic send_request(input logic rt, input logic [11:0] x1, input logic [11:0] y1,
			input logic [11:0] x2, input logic [11:0] y2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			req_type <= 1'($urandom_range(1)); start_x <= 12'($urandom);
			start_y <= 12'($urandom); end_x <= 12'($urandom); end_y <= 12'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt; start_x <= x1; start_y <= y1; end_x <= x2; end_y <= y2;
		do @(posedge clk); while (in_stall);
		predict_pixels(rt, x1, y1, x2, y2);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_COLOR: m_color = val;
			CFG_ENABLE: m_enable = val[0];
			CFG_LEFT: m_left = {1'b0, val[11:0]};
			CFG_TOP: m_top = {1'b0, val[11:0]};
			CFG_RIGHT: m_right = val[12:0];
			CFG_BOTTOM: m_bottom = val[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic walk_line(input logic [11:0] x1, input logic [11:0] y1,
			input logic [11:0] x2, input logic [11:0] y2, input int steps);
		send_request(REQ_LOAD, x1, y1, x2, y2);
		repeat (steps) send_request(REQ_STEP, 12'($urandom), 12'($urandom),
			12'($urandom), 12'($urandom));
	endtask

	task automatic test_directed();
		send_request(REQ_STEP, 0, 0, 0, 0);
		walk_line(0, 0, 0, 0, 3);
		walk_line(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 2);
		walk_line(0, 0, 12'hFFF, 12'hFFF, 4);
		walk_line(12'hFFF, 0, 0, 12'hFFF, 4);
		walk_line(5, 3, 9, 1, 6);
		walk_line(10, 2, 13, 20, 5);
		walk_line(7, 7, 8, 7, 3);
		drain();
	endtask

	task automatic test_registers();
		write_reg(CFG_COLOR, 32'h80_123456);
		write_reg(CFG_LEFT, 32'd4);
		write_reg(CFG_TOP, 32'd4);
		write_reg(CFG_RIGHT, 32'd12);
		write_reg(CFG_BOTTOM, 32'd12);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		walk_line(2, 3, 15, 9, 16);
		drain();
		write_reg(CFG_ENABLE, 0);
		walk_line(1, 1, 6, 4, 3);
		drain();
		write_reg(CFG_ENABLE, 1);
		write_reg(CFG_COLOR, 32'h00FF_FFFF);
		write_reg(CFG_LEFT, 32'hFFF);
		write_reg(CFG_TOP, 32'hFFF);
		write_reg(CFG_RIGHT, 0);
		write_reg(CFG_BOTTOM, 0);
		send_request(REQ_STEP, 0, 0, 0, 0);
		send_request(REQ_STEP, 0, 0, 0, 0);
		drain();
	endtask

	task automatic random_lines(input int n);
		logic [11:0] x1, y1, x2, y2;
		int k;
		for (int i = 0; i < n; i += k + 1) begin
			x1 = 12'($urandom); y1 = 12'($urandom);
			if ($urandom_range(3) == 0) begin
				x2 = 12'($urandom); y2 = 12'($urandom);
			end else begin
				x2 = x1 + 12'($urandom_range(40)) - 12'd20;
				y2 = y1 + 12'($urandom_range(40)) - 12'd20;
			end
			k = $urandom_range(25);
			walk_line(x1, y1, x2, y2, k);
			if ($urandom_range(9) == 0) send_request(REQ_STEP, 0, 0, 0, 0);
		end
		drain();
	endtask

	task automatic random_config();
		write_reg(CFG_COLOR, $urandom);
		write_reg(CFG_ENABLE, 32'($urandom_range(7) != 0));
		write_reg(CFG_LEFT, $urandom_range(4095));
		write_reg(CFG_TOP, $urandom_range(4095));
		write_reg(CFG_RIGHT, $urandom_range(4096));
		write_reg(CFG_BOTTOM, $urandom_range(4096));
	endtask

	task automatic test_random();
		int modes[4][2] = '{'{0, 0}, '{81, 0}, '{0, 81}, '{37, 37}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = modes[p][0];
			stall_pct = modes[p][1];
			random_config();
			write_reg(CFG_ENABLE, 1);
			random_lines(250);
			random_config();
			random_lines(130);
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		model_reset();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_registers();
		test_random();
		drain();
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
design/alr_pkg.sv
design/alr_ctrl.sv
design/alr_datapath.sv
design/antialiased_line_rasterizer_core.sv
design/alr_checker.sv
verif/antialiased_line_rasterizer_core_tb.sv
